FILE: rtl/fbt_pkg.sv
// Shared types and constants for the failed-login ban table.
`default_nettype none

package fbt_pkg;

    // Table depth default
    localparam int FBT_ENTRIES = 16;

    // Field widths
    localparam int ADDR_W = 32;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 8;
    localparam int END_W  = TIME_W + 1;
    localparam int CFG_IDX_W = 8;

    // Request codes
    localparam logic [1:0] REQ_CHECK   = 2'd0;
    localparam logic [1:0] REQ_FAIL    = 2'd1;
    localparam logic [1:0] REQ_SUCCESS = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAN_LENGTH     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THRESHOLD = 8'd1;

    // Register reset values
    localparam logic [TIME_W-1:0] BAN_LENGTH_RST     = 32'd300;
    localparam logic [CNT_W-1:0]  FAIL_THRESHOLD_RST = 8'd5;

    // Scan token passed from cell to cell
    typedef struct packed {
        logic live;
        logic found;
        logic free_seen;
        logic banned;
        logic started;
    } tok_t;

    // Commit command broadcast to all cells
    typedef struct packed {
        logic fail_go;
        logic clear_go;
        logic use_match;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/fbt_cell.sv
// One table entry: key, failure count and ban end, with scan and commit logic.
`default_nettype none

module fbt_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fbt_pkg::tok_t               prev_tok,
    output fbt_pkg::tok_t                    next_tok,
    input  wire fbt_pkg::cmd_t               cmd,
    input  wire logic [fbt_pkg::ADDR_W-1:0]  req_addr,
    input  wire logic [fbt_pkg::TIME_W-1:0]  req_now,
    input  wire logic [fbt_pkg::TIME_W-1:0]  ban_length,
    input  wire logic [fbt_pkg::CNT_W-1:0]   fail_threshold
);
    import fbt_pkg::*;

    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [END_W-1:0]  end_reg, end_next;
    logic              is_match_reg, is_match_next;
    logic              is_free_reg, is_free_next;
    tok_t              tok_reg, tok_next;

    logic              match;
    logic              free_cand;
    logic [CNT_W-1:0]  inc;
    logic [END_W-1:0]  now_ext;
    logic              sel;
    logic [CNT_W-1:0]  base;
    logic [CNT_W-1:0]  new_cnt;

    assign now_ext = {1'b0, req_now};

    // scan side
    always_comb
    begin
        match     = valid_reg && (key_reg == req_addr);
        free_cand = !valid_reg || ((cnt_reg == '0) && (end_reg <= now_ext));
        inc       = cnt_reg + CNT_W'(1);

        tok_next.live      = prev_tok.live;
        tok_next.found     = prev_tok.found | match;
        tok_next.free_seen = prev_tok.free_seen | free_cand;
        tok_next.banned    = prev_tok.banned | (match && (now_ext < end_reg));
        tok_next.started   = prev_tok.started | (match && (inc >= fail_threshold));

        is_match_next = is_match_reg;
        is_free_next  = is_free_reg;
        if (prev_tok.live)
        begin
            is_match_next = match;
            is_free_next  = free_cand && !prev_tok.free_seen;
        end
    end

    // commit side
    always_comb
    begin
        sel     = cmd.use_match ? is_match_reg : is_free_reg;
        base    = cmd.use_match ? cnt_reg : '0;
        new_cnt = base + CNT_W'(1);

        valid_next = valid_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        end_next   = end_reg;

        if (cmd.clear_go && is_match_reg)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.fail_go && sel)
        begin
            valid_next = 1'b1;
            key_next   = req_addr;
            if (!cmd.use_match)
            begin
                end_next = '0;
            end
            if (new_cnt >= fail_threshold)
            begin
                cnt_next = '0;
                end_next = now_ext + {1'b0, ban_length};
            end
            else
            begin
                cnt_next = new_cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            is_match_reg <= 1'b0;
            is_free_reg  <= 1'b0;
            tok_reg      <= '0;
        end
        else
        begin
            valid_reg    <= valid_next;
            is_match_reg <= is_match_next;
            is_free_reg  <= is_free_next;
            tok_reg      <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        cnt_reg <= cnt_next;
        end_reg <= end_next;
    end

    assign next_tok = tok_reg;

endmodule

`default_nettype wire

FILE: rtl/failed_login_ban_table.sv
// Failed-login ban table: a row of entry cells scanned by a token, then one commit.
// Requests are taken one at a time: a new one is accepted only in the idle state,
// after the token has rippled through the row and the last one has committed.
// Result waits in an output register; a stalled output holds only the commit step.
// Reset clears all entry valid bits, the controller and loads ban_length 300, threshold 5.
`default_nettype none

module failed_login_ban_table #(
    parameter int TABLE_ENTRIES = fbt_pkg::FBT_ENTRIES
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // config write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fbt_pkg::TIME_W-1:0]     cfg_data,
    // request channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     req_type,
    input  wire logic [fbt_pkg::ADDR_W-1:0]     source_addr,
    input  wire logic [fbt_pkg::TIME_W-1:0]     now_seconds,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                is_banned,
    output logic                                ban_started,
    output logic                                table_full
);
    import fbt_pkg::*;

    // config registers
    logic [TIME_W-1:0] ban_length_reg, ban_length_next;
    logic [CNT_W-1:0]  fail_thr_reg, fail_thr_next;

    // captured request word
    logic [1:0]        req_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [TIME_W-1:0] now_reg;

    state_t state_reg, state_next;
    tok_t   launch_reg, launch_next;
    tok_t   res_reg, res_next;
    tok_t   chain [TABLE_ENTRIES+1];
    cmd_t   cmd;

    logic   in_fire;
    logic   can_out;
    logic   commit_go;

    logic   out_valid_reg, out_valid_next;
    logic   banned_reg, banned_next;
    logic   started_reg, started_next;
    logic   full_reg, full_next;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign can_out   = !out_valid_reg || out_ready;

    // config writes; the host must write only while no word is in flight (not enforced here)
    always_comb
    begin
        ban_length_next = ban_length_reg;
        fail_thr_next   = fail_thr_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BAN_LENGTH:     ban_length_next = cfg_data;
                CFG_FAIL_THRESHOLD: fail_thr_next   = cfg_data[CNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chain[TABLE_ENTRIES].live)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (can_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        commit_go = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready  = 1'b1;
            ST_SCAN:   ;
            ST_COMMIT: commit_go = can_out;
            default:   ;
        endcase
    end

    // token launch and capture at the tail of the row
    always_comb
    begin
        launch_next      = '0;
        launch_next.live = in_fire;
        res_next = res_reg;
        if ((state_reg == ST_SCAN) && chain[TABLE_ENTRIES].live)
        begin
            res_next = chain[TABLE_ENTRIES];
        end
    end

    // commit broadcast: a found entry wins, else the first reusable one
    always_comb
    begin
        cmd.use_match = res_reg.found;
        cmd.fail_go   = commit_go && (req_reg == REQ_FAIL)
                        && (res_reg.found || res_reg.free_seen);
        cmd.clear_go  = commit_go && (req_reg == REQ_SUCCESS) && res_reg.found;
    end

    // result word
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        banned_next    = banned_reg;
        started_next   = started_reg;
        full_next      = full_reg;
        if (commit_go)
        begin
            out_valid_next = 1'b1;
            banned_next    = (req_reg == REQ_CHECK) && res_reg.banned;
            // a fresh entry holds count 1, so it starts a ban when threshold <= 1
            started_next   = (req_reg == REQ_FAIL)
                             && (res_reg.found ? res_reg.started
                                 : (res_reg.free_seen && (fail_thr_reg <= CNT_W'(1))));
            full_next      = (req_reg == REQ_FAIL) && !res_reg.found && !res_reg.free_seen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ban_length_reg <= BAN_LENGTH_RST;
            fail_thr_reg   <= FAIL_THRESHOLD_RST;
            launch_reg     <= '0;
            res_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ban_length_reg <= ban_length_next;
            fail_thr_reg   <= fail_thr_next;
            launch_reg     <= launch_next;
            res_reg        <= res_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg  <= req_type;
            addr_reg <= source_addr;
            now_reg  <= now_seconds;
        end
        banned_reg  <= banned_next;
        started_reg <= started_next;
        full_reg    <= full_next;
    end

    // row of entry cells; token moves one cell per cycle
    assign chain[0] = launch_reg;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        fbt_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .prev_tok       (chain[i]),
            .next_tok       (chain[i+1]),
            .cmd            (cmd),
            .req_addr       (addr_reg),
            .req_now        (now_reg),
            .ban_length     (ban_length_reg),
            .fail_threshold (fail_thr_reg)
        );
    end

    assign out_valid   = out_valid_reg;
    assign is_banned   = banned_reg;
    assign ban_started = started_reg;
    assign table_full  = full_reg;

endmodule

`default_nettype wire

FILE: test/ban_verdict_checker.sv
// Checker for the ban table: tracks the table, predicts each verdict and compares it.
`timescale 1ns / 100ps

module ban_verdict_checker #(
    parameter int ENTRIES = fbt_pkg::FBT_ENTRIES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [fbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fbt_pkg::TIME_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [1:0]                    req_type,
    input  wire logic [fbt_pkg::ADDR_W-1:0]    source_addr,
    input  wire logic [fbt_pkg::TIME_W-1:0]    now_seconds,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic                          is_banned,
    input  wire logic                          ban_started,
    input  wire logic                          table_full,
    output int                                 errors,
    output int                                 pending
);
    import fbt_pkg::*;

    typedef struct {
        logic banned;
        logic started;
        logic full;
        int   tag;
    } verdict_t;

    // shadow of the register file and the table
    logic [TIME_W-1:0] ban_len;
    logic [CNT_W-1:0]  thresh;
    logic              entry_on   [ENTRIES];
    logic [ADDR_W-1:0] entry_addr [ENTRIES];
    logic [CNT_W-1:0]  fail_cnt   [ENTRIES];
    logic [END_W-1:0]  end_time   [ENTRIES];

    verdict_t verdict_q[$];
    int       req_seq = 0;
    int       mismatch_count = 0;
    int       waiting = 0;

    assign errors  = mismatch_count;
    assign pending = waiting;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Applies one request to the shadow table and returns its verdict.
    task automatic predict_verdict(input logic [1:0] rt, input logic [ADDR_W-1:0] addr,
                                   input logic [TIME_W-1:0] t, output verdict_t v);
        int               hit;
        int               slot;
        logic [CNT_W-1:0] cnt;
        hit  = -1;
        slot = -1;
        v    = '{banned: 1'b0, started: 1'b0, full: 1'b0, tag: req_seq};
        for (int i = 0; i < ENTRIES; i++)
            if (hit < 0 && entry_on[i] && entry_addr[i] == addr)
                hit = i;
        case (rt)
            REQ_CHECK:
                if (hit >= 0 && {1'b0, t} < end_time[hit])
                    v.banned = 1'b1;
            REQ_FAIL:
            begin
                slot = hit;
                if (slot < 0)
                begin
                    // lowest entry that is empty, or idle with its ban over
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot < 0 && (!entry_on[i] ||
                            (fail_cnt[i] == '0 && end_time[i] <= {1'b0, t})))
                            slot = i;
                    if (slot >= 0)
                    begin
                        entry_on[slot]   = 1'b1;
                        entry_addr[slot] = addr;
                        fail_cnt[slot]   = '0;
                        end_time[slot]   = '0;
                    end
                end
                if (slot < 0)
                    v.full = 1'b1;
                else
                begin
                    cnt = fail_cnt[slot] + 1'b1;
                    if (cnt >= thresh)
                    begin
                        end_time[slot] = {1'b0, t} + {1'b0, ban_len};
                        fail_cnt[slot] = '0;
                        v.started      = 1'b1;
                    end
                    else
                        fail_cnt[slot] = cnt;
                end
            end
            REQ_SUCCESS:
                if (hit >= 0)
                    entry_on[hit] = 1'b0;
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        if (!rst_n)
        begin
            ban_len = BAN_LENGTH_RST;
            thresh  = FAIL_THRESHOLD_RST;
            for (int i = 0; i < ENTRIES; i++)
                entry_on[i] = 1'b0;
            verdict_q.delete();
            waiting <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_BAN_LENGTH:     ban_len = cfg_data;
                    CFG_FAIL_THRESHOLD: thresh  = cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            if (in_valid && in_ready)
            begin
                predict_verdict(req_type, source_addr, now_seconds, v);
                verdict_q = {verdict_q, v};
                req_seq++;
            end
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %b%b%b",
                                              is_banned, ban_started, table_full));
                else
                begin
                    v = verdict_q.pop_front();
                    if (is_banned !== v.banned)
                        report_mismatch($sformatf("req %0d is_banned got %b want %b",
                                                  v.tag, is_banned, v.banned));
                    if (ban_started !== v.started)
                        report_mismatch($sformatf("req %0d ban_started got %b want %b",
                                                  v.tag, ban_started, v.started));
                    if (table_full !== v.full)
                        report_mismatch($sformatf("req %0d table_full got %b want %b",
                                                  v.tag, table_full, v.full));
                end
            end
            waiting <= verdict_q.size();
        end
    end

endmodule

FILE: test/failed_login_ban_table_test.sv
// Top of the ban table testbench: clock, reset, stimulus, config phases and verdict.
`timescale 1ns / 100ps

module failed_login_ban_table_test;
    import fbt_pkg::*;

    localparam int                   ENTRIES      = FBT_ENTRIES;
    localparam int                   KEY_POOL     = 24;   // more keys than entries: fills the table
    localparam logic [1:0]           REQ_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;
    // receiver stall patterns
    localparam int                   SINK_OPEN    = 0;
    localparam int                   SINK_CHOPPY  = 1;
    localparam int                   SINK_SLOW    = 2;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [TIME_W-1:0]    cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic [1:0]           req_type    = '0;
    logic [ADDR_W-1:0]    source_addr = '0;
    logic [TIME_W-1:0]    now_seconds = '0;
    logic                 out_ready   = 1'b0;
    wire logic            cfg_ready;
    wire logic            in_ready;
    wire logic            out_valid;
    wire logic            is_banned;
    wire logic            ban_started;
    wire logic            table_full;
    int                   errors;
    int                   pending;

    logic [ADDR_W-1:0]    key_pool [KEY_POOL];
    int                   sink_mode = SINK_OPEN;
    int                   sink_left = 0;

    always #5 clk = ~clk;

    failed_login_ban_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .source_addr (source_addr),
        .now_seconds (now_seconds),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_banned   (is_banned),
        .ban_started (ban_started),
        .table_full  (table_full)
    );

    ban_verdict_checker #(.ENTRIES(ENTRIES)) verdicts (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .source_addr (source_addr),
        .now_seconds (now_seconds),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_banned   (is_banned),
        .ban_started (ban_started),
        .table_full  (table_full),
        .errors      (errors),
        .pending     (pending)
    );

    // Result sink: switches between always-ready, coin-flip stalls and long stalls
    // after runs of random length, so back-pressure lands on the commit step.
    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode <= $urandom_range(SINK_OPEN, SINK_SLOW);
            sink_left <= $urandom_range(20, 200);
        end
        else
            sink_left <= sink_left - 1;
        case (sink_mode)
            SINK_OPEN:   out_ready <= 1'b1;
            SINK_CHOPPY: out_ready <= ($urandom_range(0, 1) == 1);
            default:     out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Presents one request word and returns at the edge it is taken.
    // Valid is left high so a following word goes out back to back.
    task automatic send_req(input logic [1:0] rt, input logic [ADDR_W-1:0] addr,
                            input logic [TIME_W-1:0] t);
        in_valid    <= 1'b1;
        req_type    <= rt;
        source_addr <= addr;
        now_seconds <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Gap between sender bursts.
    task automatic pause(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // One register word; cfg_valid stays high for back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Stops the sender and waits for every outstanding verdict. The first edge
    // is always taken so the count includes a word accepted right now.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // New register settings, written only once the table is idle.
    task automatic retune(input logic [TIME_W-1:0] ban, input logic [TIME_W-1:0] thr_word,
                          input logic with_stray);
        settle();
        // a write to an unmapped index must leave both registers alone
        if (with_stray)
            write_reg(CFG_UNMAPPED, $urandom());
        write_reg(CFG_BAN_LENGTH, ban);
        write_reg(CFG_FAIL_THRESHOLD, thr_word);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic. Most words hit a small key pool so entries build up counts,
    // get banned, expire and get reused; time mostly moves forward in small steps
    // so bans run out within the phase, with the odd jump anywhere in the range.
    task automatic random_phase(input int count);
        int                burst_left;
        int                counted;
        int                pick;
        logic [1:0]        rt;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] clock_s;
        burst_left = 0;
        counted    = 0;
        clock_s    = $urandom();
        while (counted < count)
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    pause($urandom_range(1, 12));
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                rt = REQ_FAIL;
            else if (pick < 80)
                rt = REQ_CHECK;
            else if (pick < 96)
                rt = REQ_SUCCESS;
            else
                rt = REQ_UNUSED;
            if ($urandom_range(0, 9) != 0)
                addr = key_pool[$urandom_range(0, KEY_POOL - 1)];
            else
                addr = $urandom();
            if ($urandom_range(0, 11) != 0)
                clock_s = clock_s + $urandom_range(0, 25);
            else
                clock_s = $urandom();
            send_req(rt, addr, clock_s);
            // type 3 only yields an all-low result; it does not count toward the phase
            if (rt != REQ_UNUSED)
                counted++;
        end
    endtask

    initial
    begin
        logic [TIME_W-1:0] thr_word;
        foreach (key_pool[i])
            key_pool[i] = $urandom();

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at reset settings (ban 300 s, threshold 5).
        send_req(REQ_CHECK, '0, '0);                        // unknown source: not banned
        repeat (5)
            send_req(REQ_FAIL, '1, '1);                     // fifth one starts the ban
        send_req(REQ_CHECK, '1, '1);                        // ban end past 2^32: still banned
        send_req(REQ_FAIL, '0, '0);                         // fresh entry, count 1
        send_req(REQ_SUCCESS, '1, $urandom());              // clears the banned entry
        send_req(REQ_CHECK, '1, '0);
        send_req(REQ_SUCCESS, 32'h1234_5678, $urandom());   // success for unknown source
        send_req(REQ_UNUSED, $urandom(), $urandom());       // ignored, all flags low
        send_req(REQ_SUCCESS, '0, '0);
        random_phase(250);

        // Zero-length bans: every failure bans and the entry is reusable at once.
        retune('0, 32'd1, 1'b0);
        random_phase(200);

        // Longest ban, highest threshold: counts pile up and the table fills.
        retune('1, 32'd255, 1'b0);
        random_phase(250);

        // Threshold drops under the stored counts: next failure bans.
        retune(32'd20, 32'd2, 1'b0);
        random_phase(200);

        // Threshold field of zero (upper data bits set): every failure bans.
        retune(BAN_LENGTH_RST, 32'hFFFF_FF00, 1'b1);
        random_phase(200);

        // Random settings, junk in the unused data bits.
        thr_word      = $urandom();
        thr_word[7:0] = 8'($urandom_range(1, 8));
        retune($urandom_range(0, 600), thr_word, 1'b0);
        random_phase(300);

        retune(32'd5000, 32'd3, 1'b0);
        random_phase(250);

        settle();
        repeat (ENTRIES + 4)
            @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
